[src/wsc_pkg.sv]
// Shared types and constants for the window semblance coherence block.
package wsc_pkg;

    localparam int ACC_W  = 64;
    localparam int WIDE_W = 128;
    localparam int QUO_W  = 17;
    localparam int COH_W  = 18;

    localparam logic [QUO_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [1:0] MODE_MARFURT  = 2'd0;
    localparam logic [1:0] MODE_VARIANCE = 2'd1;
    localparam logic [1:0] MODE_VAR_FIT  = 2'd2;
    localparam logic [1:0] MODE_ABS_GAIN = 2'd3;

    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_WINDOW_X = 2'd1;
    localparam logic [1:0] REG_WINDOW_Y = 2'd2;
    localparam logic [1:0] REG_WINDOW_T = 2'd3;

    localparam logic [1:0] MSEL_DN = 2'd0;
    localparam logic [1:0] MSEL_CC = 2'd1;
    localparam logic [1:0] MSEL_ED = 2'd2;

    typedef struct packed {
        logic       load_we;
        logic       clr_acc;
        logic       p1_v;
        logic       p1_first;
        logic       p1_last;
        logic       p2_v;
        logic       p2_first;
        logic       mul_issue;
        logic [1:0] mul_idx;
        logic [1:0] mul_sel;
        logic       acc_c;
        logic       clr_q;
        logic       form;
        logic       div_first;
        logic       div_sat;
        logic       div_step;
        logic       emit;
        logic       emit_deg;
    } cmd_t;

    typedef struct packed {
        logic d_zero;
        logic e_zero;
    } stat_t;

endpackage

[src/wsc_ram.sv]
// Generic simple dual-port RAM with registered read.
module wsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[src/wsc_ctrl.sv]
// Controller: configuration registers, sequencing of load, passes, multiply and divide.
module wsc_ctrl #(
    parameter int MAX_WINDOW_X = 8,
    parameter int MAX_WINDOW_Y = 8,
    parameter int MAX_WINDOW_T = 64,
    localparam int MAX_TR = MAX_WINDOW_X * MAX_WINDOW_Y,
    localparam int NTW = $clog2(MAX_TR + 1),
    localparam int DEPTH_W = MAX_TR * MAX_WINDOW_T,
    localparam int WAW = (DEPTH_W > 1) ? $clog2(DEPTH_W) : 1,
    localparam int TAW = (MAX_WINDOW_T > 1) ? $clog2(MAX_WINDOW_T) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [6:0]         wr_data,
    output logic [1:0]         mode,
    output logic [NTW-1:0]     ntr,
    output logic [WAW-1:0]     win_waddr,
    output logic [WAW-1:0]     win_raddr,
    output logic [TAW-1:0]     mean_waddr,
    output logic [TAW-1:0]     mean_raddr,
    output wsc_pkg::cmd_t      cmd,
    input  wsc_pkg::stat_t     stat
);
    import wsc_pkg::*;

    localparam int XCW  = $clog2(MAX_WINDOW_X + 1);
    localparam int YCW  = $clog2(MAX_WINDOW_Y + 1);
    localparam int TCW  = $clog2(MAX_WINDOW_T + 1);
    localparam int TOTW = $clog2(DEPTH_W + 1);

    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_P1    = 4'd1;
    localparam logic [3:0] ST_P1W   = 4'd2;
    localparam logic [3:0] ST_CHECK = 4'd3;
    localparam logic [3:0] ST_P2    = 4'd4;
    localparam logic [3:0] ST_P2W   = 4'd5;
    localparam logic [3:0] ST_MUL   = 4'd6;
    localparam logic [3:0] ST_ACC   = 4'd7;
    localparam logic [3:0] ST_FORM  = 4'd8;
    localparam logic [3:0] ST_DIV   = 4'd9;
    localparam logic [3:0] ST_EMIT  = 4'd10;

    logic [3:0]     state_reg, state_next;
    logic [4:0]     k_reg, k_next;
    logic [TCW-1:0] t_reg, t_next;
    logic [NTW-1:0] j_reg, j_next;
    logic [WAW-1:0] addr_reg, addr_next;
    logic [WAW-1:0] load_reg, load_next;
    logic [1:0]     msel_reg, msel_next;
    logic           deg_reg, deg_next;
    logic [1:0]     mode_reg;
    logic [3:0]     wx_reg, wy_reg;
    logic [6:0]     wt_reg;
    logic           p1v_reg, p1first_reg, p1last_reg, p2v_reg, p2first_reg;
    logic [TAW-1:0] ttag_reg;

    logic [XCW-1:0]  nx;
    logic [YCW-1:0]  ny;
    logic [TCW-1:0]  nt;
    logic [TOTW-1:0] total;
    logic            accept, last_sample, j_last, t_last;

    assign nx = (wx_reg == 4'd0) ? XCW'(1) :
                ((32'(wx_reg) > MAX_WINDOW_X) ? XCW'(MAX_WINDOW_X) : XCW'(wx_reg));
    assign ny = (wy_reg == 4'd0) ? YCW'(1) :
                ((32'(wy_reg) > MAX_WINDOW_Y) ? YCW'(MAX_WINDOW_Y) : YCW'(wy_reg));
    assign nt = (wt_reg == 7'd0) ? TCW'(1) :
                ((32'(wt_reg) > MAX_WINDOW_T) ? TCW'(MAX_WINDOW_T) : TCW'(wt_reg));
    assign ntr   = NTW'(nx * ny);
    assign total = TOTW'(ntr * nt);
    assign mode  = mode_reg;
    assign busy  = (state_reg != ST_LOAD);

    assign accept      = start && !busy;
    assign last_sample = (TOTW'(load_reg) + TOTW'(1)) == total;
    assign j_last      = (j_reg == ntr - NTW'(1));
    assign t_last      = (t_reg == nt - TCW'(1));

    assign win_waddr  = load_reg;
    assign win_raddr  = addr_reg;
    assign mean_raddr = t_reg[TAW-1:0];
    assign mean_waddr = ttag_reg;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        t_next     = t_reg;
        j_next     = j_reg;
        addr_next  = addr_reg;
        load_next  = load_reg;
        msel_next  = msel_reg;
        deg_next   = deg_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (wr_en)
                begin
                    load_next = '0;
                end
                else if (accept)
                begin
                    if (last_sample)
                    begin
                        load_next  = '0;
                        state_next = ST_P1;
                        t_next     = '0;
                        j_next     = '0;
                        addr_next  = '0;
                    end
                    else
                    begin
                        load_next = load_reg + WAW'(1);
                    end
                end
            end
            ST_P1:
            begin
                if (j_last)
                begin
                    j_next = '0;
                    if (t_last)
                    begin
                        state_next = ST_P1W;
                        k_next     = '0;
                    end
                    else
                    begin
                        t_next    = t_reg + TCW'(1);
                        addr_next = WAW'(t_reg + TCW'(1));
                    end
                end
                else
                begin
                    j_next    = j_reg + NTW'(1);
                    addr_next = WAW'(addr_reg + nt);
                end
            end
            ST_P1W:
            begin
                k_next = k_reg + 5'd1;
                if (k_reg == 5'd1)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                deg_next = stat.d_zero || ((mode_reg != MODE_MARFURT) && stat.e_zero);
                t_next    = '0;
                j_next    = '0;
                addr_next = '0;
                k_next    = '0;
                if (deg_next)
                begin
                    state_next = ST_EMIT;
                end
                else if (mode_reg == MODE_MARFURT)
                begin
                    msel_next  = MSEL_DN;
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_P2;
                end
            end
            ST_P2:
            begin
                addr_next = addr_reg + WAW'(1);
                if (t_last)
                begin
                    state_next = ST_P2W;
                end
                else
                begin
                    t_next = t_reg + TCW'(1);
                end
            end
            ST_P2W:
            begin
                msel_next  = MSEL_CC;
                k_next     = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                k_next = k_reg + 5'd1;
                if (k_reg == 5'd4)
                begin
                    k_next     = '0;
                    state_next = (msel_reg == MSEL_CC) ? ST_ACC : ST_FORM;
                end
            end
            ST_ACC:
            begin
                t_next = '0;
                if (j_last)
                begin
                    msel_next  = MSEL_ED;
                    state_next = ST_MUL;
                end
                else
                begin
                    j_next     = j_reg + NTW'(1);
                    state_next = ST_P2;
                end
            end
            ST_FORM:
            begin
                k_next     = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                k_next = k_reg + 5'd1;
                if (k_reg == 5'd17)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.load_we   = accept;
        cmd.clr_acc   = accept && last_sample && !wr_en;
        cmd.p1_v      = p1v_reg;
        cmd.p1_first  = p1first_reg;
        cmd.p1_last   = p1last_reg;
        cmd.p2_v      = p2v_reg;
        cmd.p2_first  = p2first_reg;
        cmd.mul_issue = (state_reg == ST_MUL) && (k_reg < 5'd4);
        cmd.mul_idx   = k_reg[1:0];
        cmd.mul_sel   = msel_reg;
        cmd.acc_c     = (state_reg == ST_ACC);
        cmd.clr_q     = (state_reg == ST_CHECK);
        cmd.form      = (state_reg == ST_FORM);
        cmd.div_first = (state_reg == ST_DIV) && (k_reg == 5'd0);
        cmd.div_sat   = (state_reg == ST_DIV) && (k_reg == 5'd1);
        cmd.div_step  = (state_reg == ST_DIV) && (k_reg >= 5'd2);
        cmd.emit      = (state_reg == ST_EMIT);
        cmd.emit_deg  = deg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            k_reg       <= '0;
            t_reg       <= '0;
            j_reg       <= '0;
            addr_reg    <= '0;
            load_reg    <= '0;
            msel_reg    <= MSEL_DN;
            deg_reg     <= 1'b0;
            mode_reg    <= MODE_MARFURT;
            wx_reg      <= 4'd3;
            wy_reg      <= 4'd3;
            wt_reg      <= 7'd16;
            p1v_reg     <= 1'b0;
            p1first_reg <= 1'b0;
            p1last_reg  <= 1'b0;
            p2v_reg     <= 1'b0;
            p2first_reg <= 1'b0;
            ttag_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            t_reg       <= t_next;
            j_reg       <= j_next;
            addr_reg    <= addr_next;
            load_reg    <= load_next;
            msel_reg    <= msel_next;
            deg_reg     <= deg_next;
            p1v_reg     <= (state_reg == ST_P1);
            p1first_reg <= (j_reg == '0);
            p1last_reg  <= j_last;
            p2v_reg     <= (state_reg == ST_P2);
            p2first_reg <= (t_reg == '0);
            ttag_reg    <= t_reg[TAW-1:0];
            if (wr_en)
            begin
                case (wr_index)
                    REG_MODE:     mode_reg <= wr_data[1:0];
                    REG_WINDOW_X: wx_reg   <= wr_data[3:0];
                    REG_WINDOW_Y: wy_reg   <= wr_data[3:0];
                    REG_WINDOW_T: wt_reg   <= wr_data;
                    default:      mode_reg <= mode_reg;
                endcase
            end
        end
    end

    // Each multiply sequence hands on to gain accumulation or to the divide setup.
    a_mul_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && k_reg == 5'd4) |=> (state_reg == ST_ACC || state_reg == ST_FORM))
        else $error("multiply sequence did not finish in five cycles");
    // Samples are only taken while loading.
    a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |=> $stable(load_reg) || load_reg == '0)
        else $error("load count moved outside loading");
    // Accumulation of a gain term always follows a completed trace multiply.
    a_acc_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |-> ($past(state_reg) == ST_MUL && msel_reg == MSEL_CC))
        else $error("gain accumulation without its multiply");
endmodule

[src/wsc_dp.sv]
// Datapath: window and mean-trace memories, sums, shared multiplier and divider.
module wsc_dp #(
    parameter int MAX_WINDOW_X = 8,
    parameter int MAX_WINDOW_Y = 8,
    parameter int MAX_WINDOW_T = 64,
    parameter int SAMPLE_BITS  = 16,
    localparam int MAX_TR = MAX_WINDOW_X * MAX_WINDOW_Y,
    localparam int NTW = $clog2(MAX_TR + 1),
    localparam int DEPTH_W = MAX_TR * MAX_WINDOW_T,
    localparam int WAW = (DEPTH_W > 1) ? $clog2(DEPTH_W) : 1,
    localparam int TAW = (MAX_WINDOW_T > 1) ? $clog2(MAX_WINDOW_T) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [1:0]                    mode,
    input  logic [NTW-1:0]                ntr,
    input  logic [WAW-1:0]                win_waddr,
    input  logic [WAW-1:0]                win_raddr,
    input  logic [TAW-1:0]                mean_waddr,
    input  logic [TAW-1:0]                mean_raddr,
    input  wsc_pkg::cmd_t                 cmd,
    output wsc_pkg::stat_t                stat,
    output logic                          valid,
    output logic signed [wsc_pkg::COH_W-1:0] coherence,
    output logic                          degenerate
);
    import wsc_pkg::*;

    localparam int SW   = SAMPLE_BITS;
    localparam int SUMW = SW + $clog2(MAX_TR) + 1;

    logic signed [SW-1:0]     d;
    logic signed [SUMW-1:0]   ms;
    logic [SW-1:0]            win_rdata;
    logic [SUMW-1:0]          mean_rdata;
    logic signed [SUMW-1:0]   sacc_reg, sacc_new, s_reg;
    logic                     s_v_reg;
    logic signed [2*SW-1:0]   dsq;
    logic signed [2*SUMW-1:0] ssq;
    logic signed [SW+SUMW-1:0] ds;
    logic [ACC_W-1:0]         d_acc_reg, e_acc_reg;
    logic signed [ACC_W-1:0]  c_reg;
    logic [ACC_W-1:0]         cmag, mul_a, mul_b;
    logic [31:0]              half_a, half_b;
    logic [63:0]              pp_reg;
    logic [1:0]               pp_sh_reg;
    logic                     pp_v_reg;
    logic [WIDE_W-1:0]        prod_reg, q_reg, ppos_reg, pneg_reg;
    logic [WIDE_W-1:0]        rem_reg, den_reg, rem_sh;
    logic [QUO_W-1:0]         quo_reg, res;
    logic                     sat_reg, neg_reg;
    logic                     valid_reg, deg_reg;
    logic signed [COH_W-1:0]  coh_reg, coh;

    wsc_ram #(.WIDTH(SW), .DEPTH(DEPTH_W)) u_win_ram (
        .clk   (clk),
        .we    (cmd.load_we),
        .waddr (win_waddr),
        .wdata (sample),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    wsc_ram #(.WIDTH(SUMW), .DEPTH(MAX_WINDOW_T)) u_mean_ram (
        .clk   (clk),
        .we    (cmd.p1_v && cmd.p1_last),
        .waddr (mean_waddr),
        .wdata (sacc_new),
        .raddr (mean_raddr),
        .rdata (mean_rdata)
    );

    assign d        = win_rdata;
    assign ms       = mean_rdata;
    assign dsq      = d * d;
    assign ssq      = s_reg * s_reg;
    assign ds       = d * ms;
    assign sacc_new = cmd.p1_first ? SUMW'(d) : sacc_reg + SUMW'(d);
    assign cmag     = c_reg[ACC_W-1] ? ACC_W'(-c_reg) : ACC_W'(c_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            MSEL_DN:
            begin
                mul_a = d_acc_reg;
                mul_b = ACC_W'(ntr);
            end
            MSEL_CC:
            begin
                mul_a = cmag;
                mul_b = cmag;
            end
            default:
            begin
                mul_a = e_acc_reg;
                mul_b = d_acc_reg;
            end
        endcase
        half_a = cmd.mul_idx[1] ? mul_a[63:32] : mul_a[31:0];
        half_b = cmd.mul_idx[0] ? mul_b[63:32] : mul_b[31:0];
    end

    assign rem_sh = rem_reg << 1;
    assign res = sat_reg ? ONE_Q16 : ((quo_reg > ONE_Q16) ? ONE_Q16 : quo_reg);
    assign coh = neg_reg ? -COH_W'(res) : COH_W'(res);

    assign stat.d_zero = (d_acc_reg == '0);
    assign stat.e_zero = (e_acc_reg == '0);
    assign valid      = valid_reg;
    assign coherence  = coh_reg;
    assign degenerate = deg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_v_reg   <= 1'b0;
            pp_v_reg  <= 1'b0;
            valid_reg <= 1'b0;
            d_acc_reg <= '0;
            e_acc_reg <= '0;
        end
        else
        begin
            s_v_reg   <= cmd.p1_v && cmd.p1_last;
            pp_v_reg  <= cmd.mul_issue;
            valid_reg <= cmd.emit;
            if (cmd.clr_acc)
            begin
                d_acc_reg <= '0;
                e_acc_reg <= '0;
            end
            else
            begin
                if (cmd.p1_v)
                begin
                    d_acc_reg <= d_acc_reg + ACC_W'($unsigned(dsq));
                end
                if (s_v_reg)
                begin
                    e_acc_reg <= e_acc_reg + ACC_W'($unsigned(ssq));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.p1_v)
        begin
            sacc_reg <= sacc_new;
            s_reg    <= sacc_new;
        end
        if (cmd.p2_v)
        begin
            c_reg <= cmd.p2_first ? ACC_W'(ds) : c_reg + ACC_W'(ds);
        end
        if (cmd.mul_issue)
        begin
            pp_reg    <= half_a * half_b;
            pp_sh_reg <= 2'(cmd.mul_idx[1]) + 2'(cmd.mul_idx[0]);
        end
        if (cmd.mul_issue && cmd.mul_idx == 2'd0)
        begin
            prod_reg <= '0;
        end
        else if (pp_v_reg)
        begin
            prod_reg <= prod_reg + (WIDE_W'(pp_reg) << {pp_sh_reg, 5'd0});
        end
        if (cmd.clr_q)
        begin
            q_reg    <= '0;
            ppos_reg <= '0;
            pneg_reg <= '0;
        end
        else if (cmd.acc_c)
        begin
            q_reg <= q_reg + prod_reg;
            if (c_reg[ACC_W-1])
            begin
                pneg_reg <= pneg_reg + prod_reg;
            end
            else
            begin
                ppos_reg <= ppos_reg + prod_reg;
            end
        end
        if (cmd.form)
        begin
            neg_reg <= 1'b0;
            case (mode)
                MODE_MARFURT:
                begin
                    rem_reg <= WIDE_W'(e_acc_reg);
                    den_reg <= prod_reg;
                end
                MODE_VARIANCE:
                begin
                    rem_reg <= q_reg;
                    den_reg <= prod_reg;
                end
                MODE_VAR_FIT:
                begin
                    rem_reg <= q_reg << 1;
                    den_reg <= prod_reg + q_reg;
                end
                default:
                begin
                    den_reg <= prod_reg + q_reg;
                    if (ppos_reg >= pneg_reg)
                    begin
                        rem_reg <= (ppos_reg - pneg_reg) << 1;
                    end
                    else
                    begin
                        rem_reg <= (pneg_reg - ppos_reg) << 1;
                        neg_reg <= 1'b1;
                    end
                end
            endcase
        end
        if (cmd.div_first)
        begin
            sat_reg <= 1'b0;
            if (rem_reg >= den_reg)
            begin
                rem_reg <= rem_reg - den_reg;
                quo_reg <= QUO_W'(1);
            end
            else
            begin
                quo_reg <= '0;
            end
        end
        if (cmd.div_sat && rem_reg >= den_reg)
        begin
            sat_reg <= 1'b1;
        end
        if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[QUO_W-2:0], rem_sh >= den_reg};
            rem_reg <= (rem_sh >= den_reg) ? rem_sh - den_reg : rem_sh;
        end
        if (cmd.emit)
        begin
            coh_reg <= cmd.emit_deg ? '0 : coh;
            deg_reg <= cmd.emit_deg;
        end
    end

    // The mean-trace energy only grows while the first pass is running.
    a_e_growth: assert property (@(posedge clk) disable iff (!rst_n)
        (!s_v_reg && !cmd.clr_acc) |=> $stable(e_acc_reg))
        else $error("trace-sum energy changed outside the first pass");
    // A degenerate window always reports a zero value.
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && deg_reg) |-> (coh_reg == '0))
        else $error("degenerate result with nonzero coherence");
    // The result magnitude never exceeds one.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (coh_reg <= 18'sd65536 && coh_reg >= -18'sd65536))
        else $error("coherence out of range");
endmodule

[src/window_semblance_coherence.sv]
// Top level of the window semblance coherence block: controller plus datapath.
//
//   channel   | ports                          | handshake
//   ----------+--------------------------------+--------------------------------
//   request   | sample                         | taken when start=1 and busy=0
//   result    | coherence, degenerate          | valid strobe, one cycle
//   config    | wr_index, wr_data              | written when wr_en=1
//
// A window of N = nx*ny traces by T samples loads at one sample per cycle
// into the window memory. The sample that completes the window starts the
// computation and busy rises. The first pass reads every stored sample once
// to form the trace sums, the total energy D and the trace-sum energy E.
// Mode 0 then needs one 64x64 product, a setup step and a restoring divider,
// then the result strobe. Modes 1 to 3 add a second pass that reads each
// trace again to form its gain term and squares that term on the shared
// 32x32 multiplier, followed by the E*D product and the same divider.
// Reset is asynchronous and active low; it restores the default
// configuration and an empty window. The result has no backpressure: the
// strobe lasts one cycle and the block never waits on the receiver.
// A configuration write discards a partly loaded window.
module window_semblance_coherence #(
    parameter int MAX_WINDOW_X = 8,
    parameter int MAX_WINDOW_Y = 8,
    parameter int MAX_WINDOW_T = 64,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [SAMPLE_BITS-1:0]     sample,
    input  logic                              wr_en,
    input  logic [1:0]                        wr_index,
    input  logic [6:0]                        wr_data,
    output logic                              valid,
    output logic signed [wsc_pkg::COH_W-1:0]  coherence,
    output logic                              degenerate
);
    import wsc_pkg::*;

    localparam int MAX_TR  = MAX_WINDOW_X * MAX_WINDOW_Y;
    localparam int NTW     = $clog2(MAX_TR + 1);
    localparam int DEPTH_W = MAX_TR * MAX_WINDOW_T;
    localparam int WAW     = (DEPTH_W > 1) ? $clog2(DEPTH_W) : 1;
    localparam int TAW     = (MAX_WINDOW_T > 1) ? $clog2(MAX_WINDOW_T) : 1;

    // Command and status travel between the two halves as structs.
    cmd_t           cmd;
    stat_t          stat;
    logic [1:0]     mode;
    logic [NTW-1:0] ntr;
    logic [WAW-1:0] win_waddr, win_raddr;
    logic [TAW-1:0] mean_waddr, mean_raddr;

    wsc_ctrl #(
        .MAX_WINDOW_X (MAX_WINDOW_X),
        .MAX_WINDOW_Y (MAX_WINDOW_Y),
        .MAX_WINDOW_T (MAX_WINDOW_T)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .mode       (mode),
        .ntr        (ntr),
        .win_waddr  (win_waddr),
        .win_raddr  (win_raddr),
        .mean_waddr (mean_waddr),
        .mean_raddr (mean_raddr),
        .cmd        (cmd),
        .stat       (stat)
    );

    wsc_dp #(
        .MAX_WINDOW_X (MAX_WINDOW_X),
        .MAX_WINDOW_Y (MAX_WINDOW_Y),
        .MAX_WINDOW_T (MAX_WINDOW_T),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .mode       (mode),
        .ntr        (ntr),
        .win_waddr  (win_waddr),
        .win_raddr  (win_raddr),
        .mean_waddr (mean_waddr),
        .mean_raddr (mean_raddr),
        .cmd        (cmd),
        .stat       (stat),
        .valid      (valid),
        .coherence  (coherence),
        .degenerate (degenerate)
    );

    // A result only appears at the end of a computation.
    a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(busy))
        else $error("result strobe without a preceding computation");
    // Two results never come back to back.
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("result strobe lasted more than one cycle");
    // The block is idle again when a result is shown.
    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> !busy)
        else $error("block still busy while presenting its result");
endmodule

[tb/sv/tb_window_semblance_coherence.sv]
// Self-checking testbench for the window semblance coherence block.
`timescale 1ns / 1ps

module tb_window_semblance_coherence;
    import wsc_pkg::*;

    typedef struct packed {
        logic signed [COH_W-1:0] coh;
        logic                    deg;
    } coh_result_t;

    // The scoreboard keeps its own copy of the configuration and of the window
    // being loaded. When a request completes a window it computes the exact
    // coherence with wide integers and queues it for the result checker.
    class coherence_scoreboard;
        logic [1:0]  mode_reg;
        logic [3:0]  wx_reg;
        logic [3:0]  wy_reg;
        logic [6:0]  wt_reg;
        logic signed [15:0] window_q[$];
        coh_result_t expected_q[$];
        int errors;
        int windows_checked;
        int degenerate_seen;
        int negative_seen;
        int saturated_seen;

        function new();
            mode_reg = MODE_MARFURT;
            wx_reg = 4'd3;
            wy_reg = 4'd3;
            wt_reg = 7'd16;
        endfunction

        function int clamp_dim(int v, int hi);
            if (v < 1)
                return 1;
            return (v > hi) ? hi : v;
        endfunction

        function int traces();
            return clamp_dim(wx_reg, 8) * clamp_dim(wy_reg, 8);
        endfunction

        function int depth();
            return clamp_dim(wt_reg, 64);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [1:0] idx, logic [6:0] val);
            case (idx)
                REG_MODE:     mode_reg = val[1:0];
                REG_WINDOW_X: wx_reg = val[3:0];
                REG_WINDOW_Y: wy_reg = val[3:0];
                REG_WINDOW_T: wt_reg = val;
                default: ;
            endcase
            window_q.delete();
        endfunction

        function logic [127:0] mag(longint v);
            return (v < 0) ? 128'(-v) : 128'(v);
        endfunction

        // floor(num * 2^16 / den), saturated at one in Q1.16.
        function logic [16:0] ratio(logic [127:0] num, logic [127:0] den);
            logic [127:0] quo;
            if (den == 0)
                return 17'd0;
            if (num >= (den << 1))
                return ONE_Q16;
            quo = (num << 16) / den;
            return (quo > 128'(ONE_Q16)) ? ONE_Q16 : quo[16:0];
        endfunction

        function coh_result_t semblance();
            int ntr;
            int nt;
            longint trace_sum[64];
            longint gain;
            logic [127:0] e_sum;
            logic [127:0] d_sum;
            logic [127:0] q_sum;
            logic [127:0] ppos;
            logic [127:0] pneg;
            logic [127:0] sq;
            logic [127:0] num;
            logic [127:0] den;
            logic [16:0]  r;
            logic         neg;
            coh_result_t  res;
            ntr = traces();
            nt = depth();
            e_sum = 0;
            d_sum = 0;
            q_sum = 0;
            ppos = 0;
            pneg = 0;
            neg = 1'b0;
            res.coh = '0;
            res.deg = 1'b0;
            for (int t = 0; t < nt; t++)
            begin
                trace_sum[t] = 0;
                for (int j = 0; j < ntr; j++)
                begin
                    trace_sum[t] += longint'(window_q[j*nt+t]);
                    d_sum += mag(window_q[j*nt+t]) * mag(window_q[j*nt+t]);
                end
                e_sum += mag(trace_sum[t]) * mag(trace_sum[t]);
            end
            if (d_sum == 0 || (mode_reg != MODE_MARFURT && e_sum == 0))
            begin
                res.deg = 1'b1;
                return res;
            end
            if (mode_reg == MODE_MARFURT)
            begin
                r = ratio(e_sum, d_sum * ntr);
                res.coh = COH_W'(r);
                return res;
            end
            // Gain numerators: correlation of each trace with the trace sum.
            for (int j = 0; j < ntr; j++)
            begin
                gain = 0;
                for (int t = 0; t < nt; t++)
                    gain += longint'(window_q[j*nt+t]) * trace_sum[t];
                sq = mag(gain) * mag(gain);
                q_sum += sq;
                if (gain < 0)
                    pneg += sq;
                else
                    ppos += sq;
            end
            if (mode_reg == MODE_VARIANCE)
                r = ratio(q_sum, e_sum * d_sum);
            else
            begin
                den = e_sum * d_sum + q_sum;
                if (mode_reg == MODE_VAR_FIT)
                    num = q_sum << 1;
                else if (ppos >= pneg)
                    num = (ppos - pneg) << 1;
                else
                begin
                    num = (pneg - ppos) << 1;
                    neg = 1'b1;
                end
                r = ratio(num, den);
            end
            res.coh = neg ? -COH_W'(r) : COH_W'(r);
            return res;
        endfunction

        function void note_sample(logic signed [15:0] s);
            window_q.push_back(s);
            if (window_q.size() >= traces() * depth())
            begin
                expected_q.push_back(semblance());
                window_q.delete();
            end
        endfunction

        function void check_result(logic signed [COH_W-1:0] coh, logic deg);
            coh_result_t exp_r;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: coherence %0d degenerate %0d", coh, deg);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            windows_checked++;
            if (exp_r.deg)
                degenerate_seen++;
            if (exp_r.coh < 0)
                negative_seen++;
            if (exp_r.coh == COH_W'(ONE_Q16))
                saturated_seen++;
            if (coh !== exp_r.coh)
            begin
                $error("coherence: expected %0d, actual %0d", exp_r.coh, coh);
                errors++;
            end
            if (deg !== exp_r.deg)
            begin
                $error("degenerate: expected %0d, actual %0d", exp_r.deg, deg);
                errors++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic signed [15:0]      sample;
    logic                    wr_en;
    logic [1:0]              wr_index;
    logic [6:0]              wr_data;
    logic                    valid;
    logic signed [COH_W-1:0] coherence;
    logic                    degenerate;

    coherence_scoreboard sb;
    int requests_sent;
    int burst_left;
    int mode_hits[4];
    longint base_trace[64];

    window_semblance_coherence DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .sample     (sample),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .valid      (valid),
        .coherence  (coherence),
        .degenerate (degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog. The largest window finishes well inside this limit and the
    // random part uses mostly small ones, so this leaves a wide margin.
    initial
    begin
        #20ms;
        $display("window_semblance_coherence verification failed");
        $finish;
    end

    // Both channels are observed at the clock edge, using the values that
    // were present just before it. A request is taken on start with busy low.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_sample(sample);
            if (valid)
                sb.check_result(coherence, degenerate);
        end
    end

    // Drives one request. The sender works in bursts: when a burst runs out it
    // drops start for a random gap, which may be zero, and sometimes runs a long burst.
    task automatic send_sample(logic signed [15:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        start <= 1'b1;
        sample <= v;
        do
            @(posedge clk);
        while (busy);
        requests_sent++;
    endtask

    // Waits until every expected result has arrived and the block is idle.
    // A partly loaded window produces nothing, so a few extra cycles follow.
    task automatic wait_idle();
        start <= 1'b0;
        repeat (2) @(posedge clk);
        while (sb.pending() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic configure(logic [1:0] m, int wx, int wy, int wt);
        wait_idle();
        write_reg(REG_MODE, 7'(m));
        write_reg(REG_WINDOW_X, 7'(wx));
        write_reg(REG_WINDOW_Y, 7'(wy));
        write_reg(REG_WINDOW_T, 7'(wt));
        mode_hits[m]++;
    endtask

    // Sends one whole window in the current configuration. The flavor picks
    // the kind of data: full-range noise, small values, traces that share a
    // common wavelet plus noise (high coherence), all zero, or full-scale.
    task automatic send_window(int flavor);
        int ntr;
        int nt;
        int noise;
        longint v;
        ntr = sb.traces();
        nt = sb.depth();
        noise = $urandom_range(0, 2000);
        for (int t = 0; t < nt; t++)
            base_trace[t] = longint'($signed(16'($urandom))) / 2;
        for (int i = 0; i < ntr * nt; i++)
        begin
            case (flavor)
                0: v = longint'($signed(16'($urandom)));
                1: v = longint'($urandom_range(0, 40)) - 20;
                2: v = base_trace[i % nt] + longint'($urandom_range(0, 2 * noise)) - noise;
                3: v = 0;
                default: v = $urandom_range(0, 1) ? -32768 : 32767;
            endcase
            send_sample(16'(v));
        end
    endtask

    initial
    begin
        sb = new();
        requests_sent = 0;
        burst_left = 0;
        rst_n = 1'b0;
        start = 1'b0;
        sample = '0;
        wr_en = 1'b0;
        wr_index = REG_MODE;
        wr_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One window in the reset configuration: Marfurt, 3x3 traces, 16 deep.
        send_window(0);

        // A single full-scale trace is perfectly coherent; zeros are degenerate.
        configure(MODE_MARFURT, 1, 1, 1);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(16'sd0);

        // Two opposite traces: the trace sum vanishes. Marfurt gives zero with
        // no flag; the variance modes flag zero mean-trace energy.
        for (int m = 0; m < 4; m++)
        begin
            configure(2'(m), 2, 1, 1);
            send_sample(16'sd5);
            send_sample(-16'sd5);
            send_sample(16'sd0);
            send_sample(16'sd0);
        end

        // Absolute gain with the negative gains dominating gives a negative result.
        configure(MODE_ABS_GAIN, 3, 1, 1);
        send_sample(16'sd10);
        send_sample(-16'sd6);
        send_sample(-16'sd6);

        // A partly loaded window is dropped by a configuration write.
        configure(MODE_VARIANCE, 2, 2, 4);
        send_sample(16'sd1234);
        send_sample(-16'sd77);
        configure(MODE_VAR_FIT, 2, 2, 4);
        send_window(2);

        // Out-of-range sizes clamp: zero to one, large values to the maximum.
        configure(MODE_VAR_FIT, 0, 1, 127);
        send_window(2);
        configure(MODE_ABS_GAIN, 15, 15, 0);
        send_window(4);
        configure(MODE_MARFURT, 8, 8, 4);
        send_window(0);

        // Random part: mostly small windows, a few medium and clamped ones,
        // now and then a window cut short by a configuration change.
        while (requests_sent < 1900)
        begin
            int sel;
            int wx;
            int wy;
            int wt;
            sel = $urandom_range(0, 19);
            if (sel < 16)
            begin
                wx = $urandom_range(1, 3);
                wy = $urandom_range(1, 3);
                wt = $urandom_range(1, 10);
            end
            else if (sel < 18)
            begin
                wx = $urandom_range(1, 8);
                wy = $urandom_range(1, 4);
                wt = $urandom_range(8, 40);
            end
            else
            begin
                wx = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
                wy = $urandom_range(0, 1) ? 0 : 1;
                wt = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
            end
            configure(2'($urandom_range(0, 3)), wx, wy, wt);
            repeat ($urandom_range(1, 6))
            begin
                sel = $urandom_range(0, 19);
                send_window(sel < 6 ? 0 : sel < 10 ? 1 : sel < 17 ? 2 : sel < 18 ? 3 : 4);
            end
            if ($urandom_range(0, 9) == 0 && sb.traces() * sb.depth() > 1)
                repeat ($urandom_range(1, sb.traces() * sb.depth() - 1))
                    send_sample(16'($urandom));
        end

        wait_idle();
        repeat (50) @(posedge clk);
        $display("Checked %0d windows over %0d requests: %0d degenerate, %0d negative, %0d at one.",
                 sb.windows_checked, requests_sent, sb.degenerate_seen,
                 sb.negative_seen, sb.saturated_seen);
        $display("Configurations per mode: marfurt %0d, variance %0d, fit %0d, abs gain %0d.",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("window_semblance_coherence verification clean");
        else
            $display("window_semblance_coherence verification failed");
        $finish;
    end

endmodule
